[rtl/lds_pkg.sv]
package lds_pkg;

    // Operand width of the coefficients, the target and the divisor.
    localparam int unsigned WIDTH = 32;
    // Shift count and bit index: both stay below WIDTH.
    localparam int unsigned CNT_W = $clog2(WIDTH);

    typedef struct packed {
        logic [WIDTH-1:0] coef_a;
        logic [WIDTH-1:0] coef_b;
        logic [WIDTH-1:0] target_c;
    } t_in_word;

    typedef struct packed {
        logic             solvable;
        logic [WIDTH-1:0] common_divisor;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic start_div;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gcd_done;
        logic gcd_zero;
        logic g_zero;
        logic div_last;
    } t_sts;

endpackage

[rtl/lds_ctrl.sv]
module lds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  lds_pkg::t_sts i_sts,
    output lds_pkg::t_cmd o_cmd
);

    lds_pkg::t_state r_state;
    lds_pkg::t_state n_state;
    logic            r_out_valid;
    logic            slot_free;

    // The output register may be written when it is empty or being taken now.
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lds_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lds_pkg::ST_GCD;
            end
            lds_pkg::ST_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = i_sts.gcd_zero ? lds_pkg::ST_FIN : lds_pkg::ST_DIV;
                end
            end
            lds_pkg::ST_DIV: begin
                if (i_sts.div_last) n_state = lds_pkg::ST_FIN;
            end
            lds_pkg::ST_FIN: begin
                if (slot_free) n_state = lds_pkg::ST_IDLE;
            end
            default: n_state = lds_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lds_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            lds_pkg::ST_GCD: begin
                o_cmd.gcd_step  = !i_sts.gcd_done;
                o_cmd.start_div = i_sts.gcd_done;
            end
            lds_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            lds_pkg::ST_FIN: begin
                o_cmd.out_load = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lds_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/lds_dpath.sv]
module lds_dpath (
    input  logic              i_clk,
    input  lds_pkg::t_cmd     i_cmd,
    input  lds_pkg::t_in_word i_in_word,
    output lds_pkg::t_sts     o_sts,
    output lds_pkg::t_out_word o_out_word
);

    logic [lds_pkg::WIDTH-1:0] r_a;
    logic [lds_pkg::WIDTH-1:0] r_b;
    logic [lds_pkg::WIDTH-1:0] r_c;
    logic [lds_pkg::CNT_W-1:0] r_k;
    logic [lds_pkg::WIDTH-1:0] r_g;
    logic [lds_pkg::WIDTH-1:0] r_r;
    logic [lds_pkg::CNT_W-1:0] r_cnt;
    lds_pkg::t_out_word        r_out;

    logic [lds_pkg::WIDTH-1:0] n_r;
    logic [lds_pkg::WIDTH:0]   trial;
    logic                      ok;

    // Restoring division: bring in the next bit of the target, subtract the
    // divisor when it fits. Only the remainder is kept.
    assign trial = {r_r, r_c[r_cnt]};

    always_comb begin
        if (trial >= {1'b0, r_g}) begin
            n_r = lds_pkg::WIDTH'(trial - {1'b0, r_g});
        end else begin
            n_r = trial[lds_pkg::WIDTH-1:0];
        end
    end

    assign ok = (r_g == '0) ? (r_c == '0) : (r_r == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_in_word.coef_a;
            r_b <= i_in_word.coef_b;
            r_c <= i_in_word.target_c;
            r_k <= '0;
        end else if (i_cmd.gcd_step) begin
            // Binary gcd, one reduction per cycle.
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + lds_pkg::CNT_W'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end

        if (i_cmd.start_div) begin
            r_g   <= (r_a | r_b) << r_k;
            r_r   <= '0;
            r_cnt <= lds_pkg::CNT_W'(lds_pkg::WIDTH - 1);
        end else if (i_cmd.div_step) begin
            r_r   <= n_r;
            r_cnt <= r_cnt - lds_pkg::CNT_W'(1);
        end

        if (i_cmd.out_load) begin
            r_out.solvable       <= ok;
            r_out.common_divisor <= r_g;
        end
    end

    assign o_sts.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_sts.gcd_zero = (r_a | r_b) == '0;
    assign o_sts.g_zero   = (r_g == '0);
    assign o_sts.div_last = (r_cnt == '0);
    assign o_out_word     = r_out;

endmodule

[rtl/linear_diophantine_solvable_top.sv]
// Linear Diophantine solvability test.
// A word on the input channel carries coefficients A and B and a target C.
// The block finds g = gcd(A, B) and reports whether C is a multiple of g,
// which is exactly when A*x + B*y = C has an integer solution; g is returned
// as well. When A and B are both zero, g is 0 and the answer is yes only for
// C equal to zero.
// Both channels use valid and stall; a word moves on an edge where valid is
// high and stall is low. One result word follows each input word.
// One word is processed at a time. After the accepting cycle the binary gcd
// loop makes one shift or one subtract per cycle, and then g is formed. A
// restoring division of C by g then runs bit by bit from the top of C,
// skipped when g is 0, and the output register is written as the input
// channel reopens.
// The result sits in an output register, so the next word is taken while a
// finished result still waits. If the receiver stalls past the end of the
// next item, that item waits in its final state until the register frees.
// Reset returns the controller to idle and empties the output register.
module linear_diophantine_solvable_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lds_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lds_pkg::t_out_word o_out_word
);

    lds_pkg::t_cmd cmd;
    lds_pkg::t_sts sts;

    // Sequencer: load, gcd loop, division, hand-off to the output register.
    lds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Operand registers, the gcd reduction, the divider and the result word.
    lds_dpath u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

`ifndef ASSERT_OFF
    // Division only runs against a non-zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !sts.g_zero)
        else $error("division step with zero divisor");

    // A result is never written over one that is still held by a stall.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // Once a word is taken the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again without processing");
`endif

endmodule
